// ----- hdl/pra_pkg.sv -----
`default_nettype none
package pra_pkg;

  localparam int unsigned PAGE_W   = 20;   // page number
  localparam int unsigned PAGES_W  = 21;   // page count / break
  localparam int unsigned ENTRY_W  = PAGE_W + PAGES_W;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_ZERO     = 3'd2,
    ST_SMALL    = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_RANGE    = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT = 2'd3;

endpackage
`default_nettype wire

// ----- hdl/pra_ram.sv -----
`default_nettype none
module pra_ram #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/page_range_allocator_top.sv -----
`default_nettype none
// Page range allocator: exact fit, then worst fit, then break extension.
// Allocate: one scan reads both tables for a free slot and a fitting range, then the result.
// Free: a scan of the used table, then of the free table (two table scans), a merge, then the
// result; a free rejected by the address checks answers without a scan.
// One item at a time; a result still held in the output register stalls the last state.
// Synchronous active-low reset clears valid bits and break, presets config; tables stay undefined.
module page_range_allocator_top
  import pra_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned PAGE_BYTES  = 4096   // power of two
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // size_bytes[31:0], free_address[63:32]
  input  wire logic [0:0]            in_tuser,   // op[0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,  // address[31:0], status[34:32], zero fill
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned SH = $clog2(PAGE_BYTES);
  localparam int unsigned NW = SIZE_W + 1 - SH;               // page count of a request
  localparam int unsigned CW = ((NW > PAGES_W + 1) ? NW : PAGES_W + 1) + 2;
  localparam int unsigned XW = (PAGE_W + SH > ADDR_W) ? PAGE_W + SH : ADDR_W;
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_AFIN, S_FCHK, S_USCAN, S_USEL, S_FSCAN, S_FMRG, S_FFIN
  } state_t;

  state_t state_r;

  // configuration
  logic [PAGE_W-1:0]  hs_r, pas_r, lim_r;
  logic [SIZE_W-1:0]  small_r;
  logic [PAGES_W-1:0] brk_r;

  // request
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] va_r;
  logic [NW-1:0]     need_r;

  // valid bits and scan control
  logic [TABLE_DEPTH-1:0] fv_r, uv_r;
  logic [IW:0]   idx_r;
  logic [IW-1:0] cidx_r;
  logic          pend_r;

  // allocate scan results
  logic               slot_ok_r;
  logic [IW-1:0]      slot_r;
  logic               pk_found_r, pk_exact_r;
  logic [IW-1:0]      pk_idx_r;
  logic [PAGE_W-1:0]  pk_start_r;
  logic [PAGES_W-1:0] pk_pages_r;

  // free scan results
  logic               u_found_r;
  logic [IW-1:0]      u_idx_r;
  logic [PAGE_W-1:0]  u_start_r;
  logic [PAGES_W-1:0] u_pages_r;
  logic [PAGES_W:0]   end_r;
  logic               prev_found_r, next_found_r, spare_found_r;
  logic [IW-1:0]      prev_idx_r, next_idx_r, spare_r;
  logic [PAGE_W-1:0]  prev_start_r;
  logic [PAGES_W-1:0] prev_pages_r, next_pages_r;
  logic [PAGE_W-1:0]  mstart_r;
  logic [PAGES_W+1:0] mpages_r;

  logic                out_tvalid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  // table RAMs: {pages, start}
  logic [ENTRY_W-1:0] frd, urd, fwd, uwd;
  logic               fwe, uwe;
  logic [IW-1:0]      fwa, uwa;

  pra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_free_tbl (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(idx_r[IW-1:0]), .rdata(frd)
  );

  pra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_used_tbl (
    .clk(clk), .we(uwe), .waddr(uwa), .wdata(uwd), .raddr(idx_r[IW-1:0]), .rdata(urd)
  );

  logic [PAGE_W-1:0]  fs, us;
  logic [PAGES_W-1:0] fp, up;
  logic               in_acc, out_free, scan_done;
  logic               chk_bad, res_fire;
  logic [SIZE_W:0]    need_sum;
  logic [CW-1:0]      need_c, fp_c, bsum;
  logic [PAGE_W-1:0]  a_start;
  logic [XW-1:0]      va_x, hs_x, pas_x, lim_x, us_x;
  logic [PAGES_W+2:0] mend;

  assign fs = frd[PAGE_W-1:0];
  assign fp = frd[ENTRY_W-1:PAGE_W];
  assign us = urd[PAGE_W-1:0];
  assign up = urd[ENTRY_W-1:PAGE_W];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign scan_done  = !pend_r && (idx_r == LAST);

  // round the byte size up to whole pages
  assign need_sum = (SIZE_W+1)'(in_tdata[SIZE_W-1:0]) + (SIZE_W+1)'(PAGE_BYTES - 1);
  assign need_c   = CW'(need_r);
  assign fp_c     = CW'(fp);
  assign bsum     = CW'(brk_r) + need_c;
  assign a_start  = pk_found_r ? pk_start_r : brk_r[PAGE_W-1:0];

  assign va_x  = XW'(va_r);
  assign hs_x  = XW'({hs_r, {SH{1'b0}}});
  assign pas_x = XW'({pas_r, {SH{1'b0}}});
  assign lim_x = XW'({lim_r, {SH{1'b0}}});
  assign us_x  = XW'({us, {SH{1'b0}}});
  assign mend  = (PAGES_W+3)'(mstart_r) + (PAGES_W+3)'(mpages_r);

  // null pointer, small-block area or outside the page area
  assign chk_bad = va_r == '0 || (va_x >= hs_x && va_x < pas_x) ||
                   !(va_x >= pas_x && va_x < lim_x);

  // a result item is loaded into the output register this cycle
  assign res_fire = out_free && (state_r == S_AFIN || state_r == S_FFIN ||
                                 (state_r == S_FCHK && chk_bad) ||
                                 (state_r == S_USEL && !u_found_r));

  // table write ports
  always_comb begin
    fwe = 1'b0;
    fwa = pk_idx_r;
    fwd = {PAGES_W'(CW'(pk_pages_r) - need_c), PAGE_W'(CW'(pk_start_r) + need_c)};
    uwe = 1'b0;
    uwa = slot_r;
    uwd = {PAGES_W'(need_c), a_start};
    unique case (state_r)
      S_AFIN: begin
        if (out_free && size_r != '0 && size_r > small_r && slot_ok_r) begin
          if (pk_found_r) begin
            fwe = !pk_exact_r;
            uwe = 1'b1;
          end else begin
            uwe = (bsum <= CW'(lim_r));
          end
        end
      end
      S_FFIN: begin
        if (out_free && mend != (PAGES_W+3)'(brk_r)) begin
          if (prev_found_r) begin
            fwe = 1'b1;
            fwa = prev_idx_r;
            fwd = {mpages_r[PAGES_W-1:0], prev_start_r};
          end else if (next_found_r) begin
            fwe = 1'b1;
            fwa = next_idx_r;
            fwd = {mpages_r[PAGES_W-1:0], mstart_r};
          end else begin
            fwe = spare_found_r;
            fwa = spare_r;
            fwd = {mpages_r[PAGES_W-1:0], mstart_r};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hs_r         <= '0;
      pas_r        <= '0;
      lim_r        <= '1;
      small_r      <= SIZE_W'(2048);
      brk_r        <= '0;
      fv_r         <= '0;
      uv_r         <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (res_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_HEAP_START:  hs_r <= cfg_wdata[PAGE_W-1:0];
          REG_AREA_START: begin
            pas_r <= cfg_wdata[PAGE_W-1:0];
            brk_r <= PAGES_W'(cfg_wdata[PAGE_W-1:0]);
          end
          REG_HEAP_LIMIT:  lim_r <= cfg_wdata[PAGE_W-1:0];
          REG_SMALL_LIMIT: small_r <= cfg_wdata;
          default: ;
        endcase
      end

      // advance the shared scan index one entry per cycle
      if (state_r == S_ASCAN || state_r == S_USCAN || state_r == S_FSCAN) begin
        if (idx_r != LAST) begin
          idx_r  <= idx_r + 1'b1;
          cidx_r <= idx_r[IW-1:0];
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            size_r     <= in_tdata[SIZE_W-1:0];
            va_r       <= in_tdata[63:32];
            need_r     <= need_sum[SIZE_W:SH];
            idx_r      <= '0;
            pend_r     <= 1'b0;
            slot_ok_r  <= 1'b0;
            pk_found_r <= 1'b0;
            pk_exact_r <= 1'b0;
            state_r    <= (in_tuser[0] == OP_FREE) ? S_FCHK : S_ASCAN;
          end
        end

        S_ASCAN: begin
          if (pend_r) begin
            if (!uv_r[cidx_r] && !slot_ok_r) begin
              slot_ok_r <= 1'b1;
              slot_r    <= cidx_r;
            end
            if (fv_r[cidx_r] && !pk_exact_r) begin
              if (fp_c == need_c) begin
                pk_exact_r <= 1'b1;
                pk_found_r <= 1'b1;
                pk_idx_r   <= cidx_r;
                pk_start_r <= fs;
                pk_pages_r <= fp;
              end else if (fp_c > need_c && (!pk_found_r || fp > pk_pages_r)) begin
                pk_found_r <= 1'b1;
                pk_idx_r   <= cidx_r;
                pk_start_r <= fs;
                pk_pages_r <= fp;
              end
            end
          end
          if (scan_done) begin
            state_r <= S_AFIN;
          end
        end

        S_AFIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (size_r == '0) begin
              out_addr_r   <= '0;
              out_status_r <= ST_ZERO;
            end else if (size_r <= small_r) begin
              out_addr_r   <= '0;
              out_status_r <= ST_SMALL;
            end else if (!slot_ok_r) begin
              out_addr_r   <= '0;
              out_status_r <= ST_FULL;
            end else if (!pk_found_r && bsum > CW'(lim_r)) begin
              out_addr_r   <= '0;
              out_status_r <= ST_NO_SPACE;
            end else begin
              if (pk_found_r) begin
                if (pk_exact_r) begin
                  fv_r[pk_idx_r] <= 1'b0;
                end
              end else begin
                brk_r <= PAGES_W'(bsum);
              end
              uv_r[slot_r] <= 1'b1;
              out_addr_r   <= ADDR_W'({a_start, {SH{1'b0}}});
              out_status_r <= ST_OK;
            end
          end
        end

        S_FCHK: begin
          // null pointer, small-block area and range checks
          idx_r     <= '0;
          pend_r    <= 1'b0;
          u_found_r <= 1'b0;
          if (chk_bad) begin
            if (out_free) begin
              out_addr_r   <= '0;
              out_status_r <= (va_r == '0) ? ST_OK :
                              (va_x >= hs_x && va_x < pas_x) ? ST_SMALL : ST_RANGE;
              state_r      <= S_IDLE;
            end
          end else begin
            state_r <= S_USCAN;
          end
        end

        S_USCAN: begin
          if (pend_r && uv_r[cidx_r] && !u_found_r && us_x == va_x) begin
            u_found_r <= 1'b1;
            u_idx_r   <= cidx_r;
            u_start_r <= us;
            u_pages_r <= up;
          end
          if (scan_done) begin
            state_r <= S_USEL;
          end
        end

        S_USEL: begin
          end_r         <= (PAGES_W+1)'(u_start_r) + (PAGES_W+1)'(u_pages_r);
          idx_r         <= '0;
          pend_r        <= 1'b0;
          prev_found_r  <= 1'b0;
          next_found_r  <= 1'b0;
          spare_found_r <= 1'b0;
          if (u_found_r) begin
            state_r <= S_FSCAN;
          end else if (out_free) begin
            out_addr_r   <= '0;
            out_status_r <= ST_UNKNOWN;
            state_r      <= S_IDLE;
          end
        end

        S_FSCAN: begin
          if (pend_r) begin
            if (fv_r[cidx_r]) begin
              if (!prev_found_r &&
                  (PAGES_W+1)'(fs) + (PAGES_W+1)'(fp) == (PAGES_W+1)'(u_start_r)) begin
                prev_found_r <= 1'b1;
                prev_idx_r   <= cidx_r;
                prev_start_r <= fs;
                prev_pages_r <= fp;
              end else if (!next_found_r && (PAGES_W+1)'(fs) == end_r) begin
                next_found_r <= 1'b1;
                next_idx_r   <= cidx_r;
                next_pages_r <= fp;
              end
            end else if (!spare_found_r) begin
              spare_found_r <= 1'b1;
              spare_r       <= cidx_r;
            end
          end
          if (scan_done) begin
            state_r <= S_FMRG;
          end
        end

        S_FMRG: begin
          mstart_r <= prev_found_r ? prev_start_r : u_start_r;
          mpages_r <= (PAGES_W+2)'(u_pages_r)
                    + (prev_found_r ? (PAGES_W+2)'(prev_pages_r) : '0)
                    + (next_found_r ? (PAGES_W+2)'(next_pages_r) : '0);
          state_r  <= S_FFIN;
        end

        S_FFIN: begin
          if (out_free) begin
            out_addr_r <= '0;
            state_r    <= S_IDLE;
            if (mend == (PAGES_W+3)'(brk_r)) begin
              // merged range touches the break: lower it
              if (prev_found_r) fv_r[prev_idx_r] <= 1'b0;
              if (next_found_r) fv_r[next_idx_r] <= 1'b0;
              brk_r          <= PAGES_W'(mstart_r);
              uv_r[u_idx_r]  <= 1'b0;
              out_status_r   <= ST_OK;
            end else if (prev_found_r) begin
              if (next_found_r) fv_r[next_idx_r] <= 1'b0;
              uv_r[u_idx_r] <= 1'b0;
              out_status_r  <= ST_OK;
            end else if (next_found_r) begin
              uv_r[u_idx_r] <= 1'b0;
              out_status_r  <= ST_OK;
            end else if (spare_found_r) begin
              fv_r[spare_r] <= 1'b1;
              uv_r[u_idx_r] <= 1'b0;
              out_status_r  <= ST_OK;
            end else begin
              out_status_r <= ST_FULL;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_status_r, out_addr_r};

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  import pra_pkg::*;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned PG_BYTES  = 4096;
  localparam int unsigned IDLE_LIMIT = 20000;   // cycles with no item moving on any side
  localparam int unsigned HOLD_LEN  = 700;      // long receiver hold-off

  // request and result items as the testbench sees them
  typedef struct packed {
    op_t         op;
    logic [31:0] size_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    status_t     status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;         // size_bytes[31:0], free_address[63:32]
  logic [0:0] in_tuser = '0;          // op[0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;             // address[31:0], status[34:32], zero fill
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_HEAP_START;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  page_range_allocator_top #(.TABLE_DEPTH(DEPTH), .PAGE_BYTES(PG_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow: its own copy of the registers, tables and break pointer.
  // ---------------------------------------------------------------------------
  logic [19:0] m_heap_start, m_area_start, m_heap_limit;
  logic [31:0] m_small_limit;
  logic        fr_valid [DEPTH];
  logic [19:0] fr_start [DEPTH];
  logic [20:0] fr_pages [DEPTH];
  logic        us_valid [DEPTH];
  logic [19:0] us_start [DEPTH];
  logic [20:0] us_pages [DEPTH];
  logic [20:0] m_break;

  int unsigned status_seen [7];
  int unsigned n_fail = 0;

  function automatic rsp_t alloc_pages(logic [31:0] size);
    rsp_t r;
    int slot;
    int pick;
    longint unsigned need, start;
    r.address = '0;
    slot = -1;
    pick = -1;
    if (size == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (size <= m_small_limit) begin
      r.status = ST_SMALL;
      return r;
    end
    need = (longint'(size) + PG_BYTES - 1) / PG_BYTES;
    for (int i = 0; i < DEPTH; i++)
      if (!us_valid[i] && slot < 0) slot = i;
    if (slot < 0) begin
      r.status = ST_FULL;
      return r;
    end
    // exact fit on the lowest slot, else the largest larger range
    for (int i = 0; i < DEPTH; i++)
      if (pick < 0 && fr_valid[i] && fr_pages[i] == need) pick = i;
    if (pick < 0)
      for (int i = 0; i < DEPTH; i++)
        if (fr_valid[i] && fr_pages[i] > need && (pick < 0 || fr_pages[i] > fr_pages[pick]))
          pick = i;
    if (pick >= 0) begin
      start = fr_start[pick];
      if (fr_pages[pick] > need) begin
        fr_start[pick] = 20'(start + need);
        fr_pages[pick] = 21'(fr_pages[pick] - need);
      end else begin
        fr_valid[pick] = 1'b0;
      end
    end else begin
      if (longint'(m_break) + need > m_heap_limit) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      start = m_break;
      m_break = 21'(m_break + need);
    end
    us_valid[slot] = 1'b1;
    us_start[slot] = 20'(start);
    us_pages[slot] = 21'(need);
    r.address = 32'(longint'(20'(start)) * PG_BYTES);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic rsp_t free_pages(logic [31:0] va);
    rsp_t r;
    int u, prv, nxt, spare;
    longint unsigned start, pages, stop, mstart, mpages;
    r.address = '0;
    r.status = ST_OK;
    u = -1; prv = -1; nxt = -1; spare = -1;
    if (va == 0) return r;
    if (va >= longint'(m_heap_start) * PG_BYTES && va < longint'(m_area_start) * PG_BYTES) begin
      r.status = ST_SMALL;
      return r;
    end
    if (!(va >= longint'(m_area_start) * PG_BYTES && va < longint'(m_heap_limit) * PG_BYTES)) begin
      r.status = ST_RANGE;
      return r;
    end
    for (int i = 0; i < DEPTH; i++)
      if (u < 0 && us_valid[i] && longint'(us_start[i]) * PG_BYTES == va) u = i;
    if (u < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    start = us_start[u];
    pages = us_pages[u];
    stop = start + pages;
    for (int i = 0; i < DEPTH; i++) begin
      if (!fr_valid[i]) continue;
      if (prv < 0 && longint'(fr_start[i]) + fr_pages[i] == start) prv = i;
      else if (nxt < 0 && fr_start[i] == stop) nxt = i;
    end
    mstart = (prv >= 0) ? fr_start[prv] : start;
    mpages = pages;
    if (prv >= 0) mpages += fr_pages[prv];
    if (nxt >= 0) mpages += fr_pages[nxt];
    if (mstart + mpages == m_break) begin
      // merged range touches the break: pull the break down
      if (prv >= 0) fr_valid[prv] = 1'b0;
      if (nxt >= 0) fr_valid[nxt] = 1'b0;
      m_break = 21'(mstart);
    end else if (prv >= 0) begin
      fr_pages[prv] = 21'(mpages);
      if (nxt >= 0) fr_valid[nxt] = 1'b0;
    end else if (nxt >= 0) begin
      fr_start[nxt] = 20'(mstart);
      fr_pages[nxt] = 21'(mpages);
    end else begin
      for (int i = 0; i < DEPTH; i++)
        if (spare < 0 && !fr_valid[i]) spare = i;
      if (spare < 0) begin
        r.status = ST_FULL;
        return r;
      end
      fr_valid[spare] = 1'b1;
      fr_start[spare] = 20'(mstart);
      fr_pages[spare] = 21'(mpages);
    end
    us_valid[u] = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pop pending items, predict on acceptance, insert random gaps.
  // ---------------------------------------------------------------------------
  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  req_t cur_req;
  int unsigned gap_left = 0;
  bit no_gaps = 0;               // stretches with no idling on either side
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    req_t nxt;
    logic v;
    if (rst_n) begin
      v = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(cur_req.op == OP_ALLOC ? alloc_pages(cur_req.size_bytes)
                                                       : free_pages(cur_req.free_address));
        n_accepted++;
        v = 1'b0;
        gap_left = random_gap();
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          in_tdata <= {nxt.free_address, nxt.size_bytes};
          in_tuser <= nxt.op;
          v = 1'b1;
        end
      end
      in_tvalid <= v;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, one long hold-off, compare against the
  // oldest expected result.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    rsp_t got, exp_r;
    int unsigned r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.address = out_tdata[31:0];
        got.status = status_t'(out_tdata[34:32]);
        n_results++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result address=%h status=%0d", $time,
                   got.address, got.status);
          n_fail++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.address !== exp_r.address) begin
            $display("%0t: address expected %h actual %h", $time, exp_r.address, got.address);
            n_fail++;
          end
          if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            n_fail++;
          end
          if (exp_r.status <= ST_FULL) status_seen[exp_r.status]++;
        end
        r = $urandom_range(0, 99);
        if (!hold_done && n_results >= 400) begin
          // hold off long enough for the sender to back up behind a full block
          hold_done = 1;
          stall_left = HOLD_LEN;
        end else if (!no_gaps && r >= 60) begin
          stall_left = (r < 95) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog: count cycles in which nothing moves
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n ||
        (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !in_tvalid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_rsps.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_tvalid)
      @(posedge clk);
    // every request yields a result, but leave room for the free-path tail
    repeat (2 * DEPTH + 16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HEAP_START:  m_heap_start = val[19:0];
      REG_AREA_START: begin
        m_area_start = val[19:0];
        m_break = {1'b0, val[19:0]};
      end
      REG_HEAP_LIMIT:  m_heap_limit = val[19:0];
      REG_SMALL_LIMIT: m_small_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_alloc(logic [31:0] size);
    req_t q;
    q.op = OP_ALLOC;
    q.size_bytes = size;
    q.free_address = $urandom();
    pending_reqs.push_back(q);
  endtask

  task automatic push_free(logic [31:0] va);
    req_t q;
    q.op = OP_FREE;
    q.size_bytes = $urandom();
    q.free_address = va;
    pending_reqs.push_back(q);
  endtask

  // pick the address of a live allocation, or the area start if there is none
  function automatic logic [31:0] live_address();
    int idx [$];
    int k;
    for (int i = 0; i < DEPTH; i++)
      if (us_valid[i]) idx.push_back(i);
    if (idx.size() == 0) return 32'(longint'(m_area_start) * PG_BYTES);
    k = idx[$urandom_range(0, idx.size() - 1)];
    return 32'(longint'(us_start[k]) * PG_BYTES);
  endfunction

  // one batch of well-formed traffic with random content, plus some noise
  task automatic random_batch(int unsigned n, int unsigned alloc_pct);
    int unsigned r;
    logic [31:0] pages;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // noise: raw random fields
        if ($urandom_range(0, 1)) push_alloc($urandom());
        else push_free($urandom());
      end else if ($urandom_range(0, 99) < alloc_pct) begin
        r = $urandom_range(0, 99);
        if (r < 3) push_alloc(0);
        else if (r < 8) push_alloc($urandom_range(1, m_small_limit > 0 ? 4096 : 1));
        else if (r < 12) push_alloc(32'hFFFF_F000 | $urandom_range(0, 4095));
        else begin
          pages = (r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 300);
          push_alloc(pages * PG_BYTES - $urandom_range(0, PG_BYTES - 1));
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) push_free(live_address());
        else if (r < 92) push_free(live_address() + $urandom_range(1, PG_BYTES));
        else push_free(0);
      end
    end
    wait_idle();
  endtask

  task automatic run_phase(int unsigned items, int unsigned alloc_pct);
    int unsigned done_items;
    done_items = 0;
    while (done_items < items) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      random_batch(16, alloc_pct);
      done_items += 16;
    end
    no_gaps = 0;
  endtask

  initial begin
    m_heap_start = '0;
    m_area_start = '0;
    m_heap_limit = 20'hFFFFF;
    m_small_limit = 32'd2048;
    m_break = '0;
    for (int i = 0; i < DEPTH; i++) begin
      fr_valid[i] = 1'b0; fr_start[i] = '0; fr_pages[i] = '0;
      us_valid[i] = 1'b0; us_start[i] = '0; us_pages[i] = '0;
    end
    for (int i = 0; i < 7; i++) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a small heap so the corner cases are easy to reach
    write_reg(REG_HEAP_START, 32'h100);
    write_reg(REG_AREA_START, 32'h200);
    write_reg(REG_HEAP_LIMIT, 32'h240);
    write_reg(REG_SMALL_LIMIT, 32'd8192);
    push_alloc(0);                          // zero size
    push_alloc(1);                          // small-block request
    push_alloc(32'd8192);                   // exactly at small limit
    push_alloc(32'd8193);                   // just over: 3 pages
    push_alloc(32'hFFFF_FFFF);              // no space
    push_alloc(32'd16384);                  // 4 pages
    push_alloc(32'd12288);                  // 3 pages
    push_free(32'h0020_0000);               // free first range
    push_alloc(32'd12288);                  // exact fit reuse
    push_free(32'h0020_3000);               // free the 4-page range: no free neighbour
    push_alloc(32'd10000);                  // worst fit split
    push_free(0);                           // null free
    push_free(32'h0010_0000);               // small-block area
    push_free(32'h0000_0FFF);               // below heap
    push_free(32'hFFFF_FFFF);               // out of range
    push_free(32'h0023_0000);               // unknown address
    push_free(32'h0020_1000);               // unknown, interior page
    push_alloc(32'd255 * 4096);             // exceeds the remaining room
    wait_idle();
    for (int i = 0; i < DEPTH; i++)
      if (us_valid[i]) push_free(32'(longint'(us_start[i]) * PG_BYTES));
    wait_idle();

    // default-like heap, balanced traffic
    write_reg(REG_AREA_START, 32'h400);
    write_reg(REG_HEAP_LIMIT, 32'h2000);
    write_reg(REG_SMALL_LIMIT, 32'd2048);
    run_phase(320, 55);
    // allocation heavy: fill the used table
    run_phase(160, 90);
    // free heavy: build up fragments and coalesce them
    run_phase(192, 20);

    // extremes: whole page space, nothing is small
    write_reg(REG_HEAP_START, 32'h0);
    write_reg(REG_AREA_START, 32'hFFF00);
    write_reg(REG_HEAP_LIMIT, 32'hFFFFF);
    write_reg(REG_SMALL_LIMIT, 32'd0);
    run_phase(240, 55);

    // tight heap so no-space is common, then all requests small, then an empty page area
    write_reg(REG_HEAP_START, 32'hFFFFF);
    write_reg(REG_AREA_START, 32'h10);
    write_reg(REG_HEAP_LIMIT, 32'h30);
    write_reg(REG_SMALL_LIMIT, 32'd4096);
    run_phase(240, 60);
    write_reg(REG_SMALL_LIMIT, 32'hFFFF_FFFF);
    run_phase(48, 50);
    write_reg(REG_AREA_START, 32'h0);
    write_reg(REG_HEAP_LIMIT, 32'h0);
    write_reg(REG_SMALL_LIMIT, 32'd1);
    run_phase(128, 60);

    wait_idle();
    $display("covered %0d requests: ok %0d, no space %0d, zero %0d, small %0d",
             n_accepted, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("unknown address %0d, out of range %0d, table full %0d",
             status_seen[4], status_seen[5], status_seen[6]);
    if (n_fail == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/pra_pkg.sv
hdl/pra_ram.sv
hdl/page_range_allocator_top.sv
tb/sv/tb_top.sv
